>>> hw/rtl/glr_pkg.sv
package glr_pkg;

  // request kinds
  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } op_e;

  // color channels
  localparam int ChanBits = 8;
  localparam int NumChan  = 3;

  // packed color, index 2 red, 1 green, 0 blue
  typedef logic [NumChan-1:0][ChanBits-1:0] rgb_t;

  // progress scale and the divider that produces it
  localparam int PctScale    = 100;
  localparam int QuoBits     = 7;
  localparam int QuoStepBits = 3;

  // divide by 100 as multiply by 5243 and shift by 19, exact below 2**15
  localparam int ProdBits     = ChanBits + QuoBits;
  localparam int RecipBits    = 13;
  localparam int RecipHundred = 5243;
  localparam int RecipShift   = 19;
  localparam int ScaledBits   = ProdBits + RecipBits;

  // command queue between front and back
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = 1;
  localparam int QueueCntBits = 2;

  // back end status seen by the top level
  typedef struct packed {
    logic busy;
    logic line_active;
  } back_status_t;

  // width of one queued command
  // op, 4 coords, 2 spans, 2 directions, error term, 2 colors
  function automatic int cmd_bits(int coord_bits);
    return 7 * coord_bits + 5 + 2 * NumChan * ChanBits;
  endfunction

endpackage

>>> hw/rtl/glr_req_if.sv
interface glr_req_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [7:0]                   start_red;
  logic [7:0]                   start_green;
  logic [7:0]                   start_blue;
  logic [7:0]                   end_red;
  logic [7:0]                   end_green;
  logic [7:0]                   end_blue;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    input  ready
  );

  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    output ready
  );
endinterface

>>> hw/rtl/glr_pix_if.sv
interface glr_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [23:0]                  pixel_color;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

>>> hw/rtl/glr_front.sv
module glr_front #(
  parameter int COORD_BITS = 12
) (
  glr_req_if.sink                                     req_i,
  output logic [glr_pkg::cmd_bits(COORD_BITS)-1:0]    cmd_o,
  output logic                                        cmd_valid_o,
  input  logic                                        cmd_ready_i
);
  import glr_pkg::*;

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ErrBits  = COORD_BITS + 2;

  typedef struct packed {
    op_e                          op;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [COORD_BITS-1:0]        span_x;
    logic [COORD_BITS-1:0]        span_y;
    logic                         x_down;
    logic                         y_down;
    logic signed [ErrBits-1:0]    err_init;
    rgb_t                         color_from;
    rgb_t                         color_to;
  } cmd_t;

  cmd_t                       cmd;
  logic signed [DiffBits-1:0] dx;
  logic signed [DiffBits-1:0] dy;
  logic [DiffBits-1:0]        adx;
  logic [DiffBits-1:0]        ady;

  // handshake passes straight to the queue
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign cmd_o       = cmd;

  // absolute deltas of the line
  always_comb begin
    dx  = DiffBits'(req_i.end_x) - DiffBits'(req_i.start_x);
    dy  = DiffBits'(req_i.end_y) - DiffBits'(req_i.start_y);
    adx = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
    ady = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
  end

  // classify and prepare the line setup
  always_comb begin
    cmd.op         = op_e'(req_i.operation);
    cmd.origin_x   = req_i.start_x;
    cmd.origin_y   = req_i.start_y;
    cmd.target_x   = req_i.end_x;
    cmd.target_y   = req_i.end_y;
    cmd.span_x     = adx[COORD_BITS-1:0];
    cmd.span_y     = ady[COORD_BITS-1:0];
    cmd.x_down     = !(req_i.start_x < req_i.end_x);
    cmd.y_down     = !(req_i.start_y < req_i.end_y);
    if (cmd.span_x > cmd.span_y) begin
      cmd.err_init = $signed(ErrBits'(cmd.span_x >> 1));
    end else begin
      cmd.err_init = -$signed(ErrBits'(cmd.span_y >> 1));
    end
    cmd.color_from = {req_i.start_red, req_i.start_green, req_i.start_blue};
    cmd.color_to   = {req_i.end_red, req_i.end_green, req_i.end_blue};
  end

endmodule

>>> hw/rtl/glr_fifo.sv
module glr_fifo #(
  parameter int DataWidth = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [DataWidth-1:0]              in_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic [DataWidth-1:0]              out_data_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [glr_pkg::QueueCntBits-1:0]  count_o
);
  import glr_pkg::*;

  logic [DataWidth-1:0]    mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q;
  logic [QueuePtrBits-1:0] rd_ptr_q;
  logic [QueueCntBits-1:0] count_q;
  logic                    push;
  logic                    pop;

  assign in_ready_o  = (count_q != QueueCntBits'(QueueDepth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QueueCntBits'(push) - QueueCntBits'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

>>> hw/rtl/glr_back.sv
module glr_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [glr_pkg::cmd_bits(COORD_BITS)-1:0]    cmd_i,
  input  logic                                        cmd_valid_i,
  output logic                                        cmd_ready_o,
  glr_pix_if.source                                   pix_o,
  output glr_pkg::back_status_t                       status_o
);
  import glr_pkg::*;

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ErrBits  = COORD_BITS + 2;
  localparam int RemBits  = COORD_BITS + QuoBits;

  typedef struct packed {
    op_e                          op;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [COORD_BITS-1:0]        span_x;
    logic [COORD_BITS-1:0]        span_y;
    logic                         x_down;
    logic                         y_down;
    logic signed [ErrBits-1:0]    err_init;
    rgb_t                         color_from;
    rgb_t                         color_to;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StDiv,
    StMul,
    StScale,
    StEmit
  } state_e;

  cmd_t cmd;
  assign cmd = cmd_t'(cmd_i);

  // control and line state
  state_e                       state_q;
  logic                         active_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_y_q;
  logic signed [COORD_BITS-1:0] org_x_q, org_y_q;
  logic [COORD_BITS-1:0]        span_x_q, span_y_q;
  logic                         x_down_q, y_down_q;
  logic signed [ErrBits-1:0]    err_q;
  rgb_t                         from_q, to_q;

  // output register
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  rgb_t                         out_color_q;
  logic                         out_last_q;

  // per pixel work registers
  logic signed [COORD_BITS-1:0] px_x_q, px_y_q;
  logic                         px_last_q;
  logic [COORD_BITS-1:0]        dist_q;
  logic [COORD_BITS-1:0]        span_div_q;
  logic                         zero_q;
  logic [RemBits-1:0]           rem_q;
  logic [QuoBits-1:0]           quo_q;
  logic [QuoStepBits-1:0]       step_q;
  logic [NumChan-1:0][ProdBits-1:0] prod_q;
  logic [NumChan-1:0][ChanBits-1:0] scl_q;

  // combinational helpers
  logic                         pop_load;
  logic                         pop_step;
  logic                         at_end;
  logic                         x_major;
  logic signed [DiffBits-1:0]   dcur;
  logic [DiffBits-1:0]          adcur;
  logic signed [ErrBits-1:0]    sx_e, sy_e;
  logic                         go_x, go_y;
  logic signed [ErrBits-1:0]    err_next;
  logic signed [COORD_BITS-1:0] inc_x, inc_y;
  logic [RemBits-1:0]           trial;
  logic                         ge;
  logic [QuoBits-1:0]           pct;
  logic [NumChan-1:0]           hi;
  logic [NumChan-1:0][ChanBits-1:0]   diff;
  logic [NumChan-1:0][ProdBits-1:0]   prod_d;
  logic [NumChan-1:0][ScaledBits-1:0] wide;
  rgb_t                         blend;

  assign cmd_ready_o = (state_q == StIdle);
  assign pop_load    = cmd_ready_o && cmd_valid_i && (cmd.op == OpLoad);
  assign pop_step    = cmd_ready_o && cmd_valid_i && (cmd.op == OpStep) && active_q;

  assign status_o.busy        = (state_q != StIdle);
  assign status_o.line_active = active_q;

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_color = out_color_q;
  assign pix_o.last_pixel  = out_last_q;

  // end test, distance along the major axis, next walk step
  always_comb begin
    at_end  = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
    x_major = (span_x_q >= span_y_q);
    if (x_major) begin
      dcur = DiffBits'(cur_x_q) - DiffBits'(org_x_q);
    end else begin
      dcur = DiffBits'(cur_y_q) - DiffBits'(org_y_q);
    end
    adcur    = dcur[DiffBits-1] ? DiffBits'(-dcur) : DiffBits'(dcur);
    sx_e     = $signed(ErrBits'(span_x_q));
    sy_e     = $signed(ErrBits'(span_y_q));
    go_x     = (err_q > -sx_e);
    go_y     = (err_q < sy_e);
    err_next = err_q - (go_x ? sy_e : ErrBits'(0)) + (go_y ? sx_e : ErrBits'(0));
    inc_x    = x_down_q ? -COORD_BITS'(1) : COORD_BITS'(1);
    inc_y    = y_down_q ? -COORD_BITS'(1) : COORD_BITS'(1);
  end

  // one restoring step of the progress divider
  always_comb begin
    trial = RemBits'(span_div_q) << step_q;
    ge    = (rem_q >= trial);
    pct   = zero_q ? '0 : quo_q;
  end

  // per channel color math
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      hi[c]     = (from_q[c] > to_q[c]);
      diff[c]   = hi[c] ? (from_q[c] - to_q[c]) : (to_q[c] - from_q[c]);
      prod_d[c] = ProdBits'(diff[c]) * ProdBits'(pct);
      wide[c]   = ScaledBits'(prod_q[c]) * ScaledBits'(RecipHundred);
      blend[c]  = hi[c] ? (from_q[c] - scl_q[c]) : (from_q[c] + scl_q[c]);
    end
  end

  // sequencer, line state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      x_down_q    <= 1'b0;
      y_down_q    <= 1'b0;
      err_q       <= '0;
      from_q      <= '0;
      to_q        <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_color_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // taken pixel leaves the output register unless a new one replaces it
      if (out_valid_q && pix_o.ready && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (pop_load) begin
            org_x_q  <= cmd.origin_x;
            org_y_q  <= cmd.origin_y;
            cur_x_q  <= cmd.origin_x;
            cur_y_q  <= cmd.origin_y;
            tgt_x_q  <= cmd.target_x;
            tgt_y_q  <= cmd.target_y;
            span_x_q <= cmd.span_x;
            span_y_q <= cmd.span_y;
            x_down_q <= cmd.x_down;
            y_down_q <= cmd.y_down;
            err_q    <= cmd.err_init;
            from_q   <= cmd.color_from;
            to_q     <= cmd.color_to;
            active_q <= 1'b1;
          end else if (pop_step) begin
            state_q <= StPrep;
            if (at_end) begin
              active_q <= 1'b0;
            end else begin
              err_q <= err_next;
              if (go_x) begin
                cur_x_q <= cur_x_q + inc_x;
              end
              if (go_y) begin
                cur_y_q <= cur_y_q + inc_y;
              end
            end
          end
        end
        StPrep: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (step_q == '0) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StScale;
        end
        StScale: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_valid_q || pix_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= px_x_q;
            out_y_q     <= px_y_q;
            out_color_q <= blend;
            out_last_q  <= px_last_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // pixel capture, divider and color pipeline registers
  always_ff @(posedge clk_i) begin
    if (pop_step) begin
      px_x_q     <= cur_x_q;
      px_y_q     <= cur_y_q;
      px_last_q  <= at_end;
      dist_q     <= adcur[COORD_BITS-1:0];
      span_div_q <= x_major ? span_x_q : span_y_q;
      zero_q     <= x_major && (span_x_q == '0);
    end
    if (state_q == StPrep) begin
      rem_q  <= RemBits'(dist_q) * RemBits'(PctScale);
      quo_q  <= '0;
      step_q <= QuoStepBits'(QuoBits - 1);
    end
    if (state_q == StDiv) begin
      if (ge) begin
        rem_q <= rem_q - trial;
      end
      quo_q  <= {quo_q[QuoBits-2:0], ge};
      step_q <= step_q - 1'b1;
    end
    if (state_q == StMul) begin
      prod_q <= prod_d;
    end
    if (state_q == StScale) begin
      for (int c = 0; c < NumChan; c++) begin
        scl_q[c] <= wide[c][RecipShift +: ChanBits];
      end
    end
  end

endmodule

>>> hw/rtl/gradient_line_rasterizer.sv
// Gradient line rasterizer: Bresenham walk with per channel color blend.
// Input channel req_i carries requests. operation 0 loads a line (two
// endpoints and two colors) and gives no output; operation 1 asks for the
// next pixel and gives one item on pix_o, with last_pixel set on the end
// point. A step request with no line loaded gives nothing.
// Requests enter a two-entry queue, so up to two are taken while the back
// end is busy or a finished pixel waits on pix_o.
// A load only updates the line state and leaves the back end idle. A
// pixel passes from leaving the queue to sitting in the output register
// through the pop, a setup state, seven steps of the progress divider
// (one quotient bit per cycle), two color multiply stages and the output
// state. The serial divider for progress limits the rate: the back end
// takes no new request until the current pixel is in the output register.
// When pix_o is stalled the pixel holds in the output register, the back
// end waits after finishing the next one, and req_i stalls once the queue
// is full. Reset clears the queue, the output register and the line, so
// steps after reset give nothing until a load.
module gradient_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  glr_req_if.sink   req_i,
  glr_pix_if.source pix_o
);
  import glr_pkg::*;

  localparam int CmdBits = cmd_bits(COORD_BITS);

  logic [CmdBits-1:0]      front_cmd;
  logic                    front_valid;
  logic                    front_ready;
  logic [CmdBits-1:0]      back_cmd;
  logic                    back_valid;
  logic                    back_ready;
  logic [QueueCntBits-1:0] q_count;
  back_status_t            status;

  // request classification
  glr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // command queue
  glr_fifo #(
    .DataWidth (CmdBits)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (front_cmd),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_data_o  (back_cmd),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .count_o     (q_count)
  );

  // line walk and color blend
  glr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .pix_o       (pix_o),
    .status_o    (status)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QueueCntBits'(QueueDepth))
    else $error("command queue overfilled");

  // empty queue offers nothing to the back end
  a_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == '0) |-> !back_valid)
    else $error("queue valid while empty");

  // the line ends only with its last pixel in flight
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.line_active) |-> status.busy)
    else $error("line closed without a pixel in work");

  // a new pixel appears only out of the back end's work
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_o.valid) |-> $past(status.busy))
    else $error("pixel output without back end work");

endmodule
